[design/oqsr_pkg.sv]
// Shared types and constants for the ordered queue search/remove unit.
// No dependencies; compile first.
package oqsr_pkg;

   localparam int DEPTH      = 16;
   localparam int VALUE_BITS = 32;

   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 2;
   localparam int WORD_BITS   = 32;

   typedef logic [OP_BITS-1:0]     op_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [VALUE_BITS-1:0]  value_type;
   typedef logic [WORD_BITS-1:0]   word_type;

   localparam op_type OP_INSERT      = 3'd0;
   localparam op_type OP_REMOVE_HEAD = 3'd1;
   localparam op_type OP_FIND_REMOVE = 3'd2;
   localparam op_type OP_FIND_NEXT   = 3'd3;
   localparam op_type OP_PEEK_HEAD   = 3'd4;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;

   // Command broadcast to every cell during an accepted transfer.
   typedef struct packed {
      logic      load;
      op_type    op;
      value_type key;
   } cmd_type;

   // Signals rippling from the head toward the tail of the cell chain.
   typedef struct packed {
      logic      is_head;     // set only into the first cell
      logic      prev_valid;  // cell to the left holds an entry
      logic      hit;         // a match exists left of this cell
      logic      prev_first;  // cell to the left is the first match
      logic      found;       // some cell has supplied the answer
      value_type res;         // answer word, zero until supplied
   } chain_type;

   // Contents handed leftward for shifting.
   typedef struct packed {
      logic      valid;
      value_type data;
   } entry_type;

endpackage

[design/oqsr_if.sv]
// Request and response channel interfaces (valid/ready handshake).
// Depends on oqsr_pkg.
interface oqsr_req_if;
   import oqsr_pkg::*;
   logic     valid;
   logic     ready;
   op_type   operation;
   word_type value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface oqsr_rsp_if;
   import oqsr_pkg::*;
   logic       valid;
   logic       ready;
   word_type   result_value;
   status_type status;
   logic       is_empty;

   modport source (output valid, output result_value, output status, output is_empty,
                   input ready);
   modport sink   (input valid, input result_value, input status, input is_empty,
                   output ready);
endinterface

[design/oqsr_cell.sv]
// One queue slot: holds an entry, compares it to the key, shifts from its
// right neighbor on removal and passes the search state to the right. Uses oqsr_pkg.
module oqsr_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  oqsr_pkg::cmd_type     cmd,
   input  oqsr_pkg::chain_type   left_in,
   output oqsr_pkg::chain_type   right_out,
   input  oqsr_pkg::entry_type   right_entry,
   output oqsr_pkg::entry_type   entry
);
   import oqsr_pkg::*;

   logic      valid_ff, valid_in;
   value_type data_ff, data_in;
   logic      match, first, hit_here, supply, shift, insert;

   always_comb begin
      match    = valid_ff && (data_ff == cmd.key);
      first    = match && !left_in.hit;
      hit_here = left_in.hit || match;

      case (cmd.op)
         OP_REMOVE_HEAD,
         OP_PEEK_HEAD:   supply = left_in.is_head && valid_ff;
         OP_FIND_REMOVE: supply = first;
         OP_FIND_NEXT:   supply = left_in.prev_first && valid_ff;
         default:        supply = 1'b0;
      endcase

      case (cmd.op)
         OP_REMOVE_HEAD: shift = 1'b1;
         OP_FIND_REMOVE: shift = hit_here;
         default:        shift = 1'b0;
      endcase

      insert = (cmd.op == OP_INSERT) && !valid_ff && left_in.prev_valid;

      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.load) begin
         if (shift) begin
            valid_in = right_entry.valid;
            data_in  = right_entry.data;
         end else if (insert) begin
            valid_in = 1'b1;
            data_in  = cmd.key;
         end
      end

      right_out.is_head    = 1'b0;
      right_out.prev_valid = valid_ff;
      right_out.hit        = hit_here;
      right_out.prev_first = first;
      right_out.found      = left_in.found || supply;
      right_out.res        = supply ? data_ff : left_in.res;

      entry.valid = valid_ff;
      entry.data  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[design/ordered_queue_search_remove_unit.sv]
// Ordered queue with search and remove, built as a chain of compare/shift cells.
// Depends on oqsr_pkg, oqsr_if (channel interfaces) and oqsr_cell.
//
//   channel   direction  payload                              transfer when
//   req_ch    in         operation[2:0], value[31:0]          valid && ready
//   rsp_ch    out        result_value[31:0], status[1:0],     valid && ready
//                        is_empty
//
// Every operation finishes in the cycle it is accepted: the key is broadcast
// to all DEPTH cells and the search state ripples once through the chain.
// The response lands in an output register and is offered in the cycle after the transfer.
// req_ch.ready is high while that register is empty or being drained, so a
// stalled consumer holds at most one response and back-pressures the input.
// Synchronous reset empties the queue and the response register; no clearing
// pass is needed since only the valid flags are reset.
module ordered_queue_search_remove_unit (
   input  logic              clock,
   input  logic              reset,
   oqsr_req_if.sink          req_ch,
   oqsr_rsp_if.source        rsp_ch
);
   import oqsr_pkg::*;

   cmd_type   cmd;
   chain_type chain [DEPTH+1];
   entry_type entries [DEPTH+1];

   logic       accept;
   logic       full, removing, removed_ok, inserted_ok;
   status_type status_calc;
   logic       empty_calc;

   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_value_ff, rsp_value_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       rsp_empty_ff, rsp_empty_in;

   // Accept whenever the response register is free or being taken.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      cmd.load = accept;
      cmd.op   = req_ch.operation;
      cmd.key  = VALUE_BITS'(req_ch.value);
   end

   // Seed the chain at the head.
   assign chain[0] = '{is_head: 1'b1, prev_valid: 1'b1, hit: 1'b0, prev_first: 1'b0,
                       found: 1'b0, res: '0};
   assign entries[DEPTH] = '{valid: 1'b0, data: '0};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      oqsr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_in     (chain[i]),
         .right_out   (chain[i+1]),
         .right_entry (entries[i+1]),
         .entry       (entries[i])
      );
   end

   // Status and emptiness after the operation.
   always_comb begin
      full        = entries[DEPTH-1].valid;
      removing    = (cmd.op == OP_REMOVE_HEAD) || (cmd.op == OP_FIND_REMOVE);
      removed_ok  = removing && chain[DEPTH].found;
      inserted_ok = (cmd.op == OP_INSERT) && !full;

      if (cmd.op == OP_INSERT) begin
         status_calc = full ? ST_FULL : ST_OK;
      end else begin
         status_calc = chain[DEPTH].found ? ST_OK : ST_NOT_FOUND;
      end

      if (inserted_ok) begin
         empty_calc = 1'b0;
      end else if (removed_ok) begin
         empty_calc = !entries[1].valid;
      end else begin
         empty_calc = !entries[0].valid;
      end
   end

   // Load the response register on a transfer in; drop it once taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = WORD_BITS'(chain[DEPTH].res);
         rsp_status_in = status_calc;
         rsp_empty_in  = empty_calc;
      end else if (rsp_ch.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.is_empty     = rsp_empty_ff;

endmodule

[design/oqsr_checker.sv]
// Port-level checks for the ordered queue unit, bound to the top level.
// Depends on oqsr_pkg.
module oqsr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input oqsr_pkg::op_type       req_operation,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input oqsr_pkg::word_type     rsp_result_value,
   input oqsr_pkg::status_type   rsp_status,
   input logic                   rsp_is_empty
);
   import oqsr_pkg::*;

   // A held response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Failed operations return a zero word.
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_value == '0)
      else $error("nonzero result on failed operation");

   // An accepted request shows its response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("response missing after transfer");

   // An insert either succeeds and leaves the queue non-empty or is rejected as full.
   a_insert_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_INSERT |=>
         (rsp_status == ST_FULL) || (rsp_status == ST_OK && !rsp_is_empty))
      else $error("bad insert response");

endmodule

bind ordered_queue_search_remove_unit oqsr_checker u_oqsr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_operation    (req_ch.operation),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status),
   .rsp_is_empty     (rsp_ch.is_empty)
);
